// File: design/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`default_nettype none
package sitda_pkg;

    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int QDEPTH         = 2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // Reciprocal of ten, exact for every 32-bit dividend with a shift of 35.
    localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } job_t;

endpackage
`default_nettype wire

// File: design/sitda_front.sv
// Input side: takes integers, splits off sign and forms the unsigned magnitude.
`default_nettype none
module sitda_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sitda_pkg::VALUE_W-1:0] s_tdata,
    output logic                               q_wr,
    output sitda_pkg::job_t                    q_wdata,
    input  wire logic                          q_full
);

    logic seen_reset_reg;

    // Hold off transfers once reset has been sampled, until a clock edge sees it released.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reset_reg <= 1'b0;
        end else begin
            seen_reset_reg <= 1'b1;
        end
    end

    assign s_tready = seen_reset_reg && !q_full;
    assign q_wr     = s_tvalid && s_tready;

    always_comb begin
        q_wdata.neg = s_tdata[sitda_pkg::VALUE_W-1];
        // two's complement negate; the most negative value maps to 2^31 unsigned
        q_wdata.mag = q_wdata.neg ? (~s_tdata + 1'b1) : s_tdata;
    end

endmodule
`default_nettype wire

// File: design/sitda_queue.sv
// Short job queue between the input side and the converter.
`default_nettype none
module sitda_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr,
    input  wire sitda_pkg::job_t wdata,
    output logic                 full,
    output logic                 rd_valid,
    input  wire logic            rd,
    output sitda_pkg::job_t      rdata
);

    localparam int PW = (sitda_pkg::QDEPTH > 1) ? $clog2(sitda_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(sitda_pkg::QDEPTH + 1);

    sitda_pkg::job_t mem [sitda_pkg::QDEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_wr;
    logic            do_rd;

    assign full     = (cnt_reg == CW'(sitda_pkg::QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr && !full;
    assign do_rd    = rd && rd_valid;
    assign rdata    = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == PW'(sitda_pkg::QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == PW'(sitda_pkg::QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/sitda_back.sv
// Converter: one decimal digit per cycle into the digit store, then emits characters.
`default_nettype none
module sitda_back #(
    parameter int MAX_DIGITS = sitda_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         q_valid,
    output logic                              q_rd,
    input  wire sitda_pkg::job_t              q_rdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [sitda_pkg::CHAR_W-1:0]      m_tdata,
    output logic                              m_tlast
);

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int VW = sitda_pkg::VALUE_W;
    localparam int DW = sitda_pkg::DIGIT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic                neg_reg;
    logic [VW-1:0]       mag_reg;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       store_reg [MAX_DIGITS];

    logic [2*VW-1:0]     prod;
    logic [VW-1:0]       quot;
    logic [VW-1:0]       rem_full;
    logic [DW-1:0]       digit;
    logic [CW-1:0]       cnt_inc;
    logic [CW-1:0]       cnt_dec;

    logic                out_load;
    logic                emit;
    logic [sitda_pkg::CHAR_W-1:0] emit_char;
    logic                emit_last;

    logic                m_tvalid_reg;
    logic [sitda_pkg::CHAR_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;

    // divide by ten through the reciprocal, remainder by shift-add back-multiply
    assign prod     = {{VW{1'b0}}, mag_reg} * {{VW{1'b0}}, sitda_pkg::RECIP10};
    assign quot     = VW'(prod >> sitda_pkg::RECIP_SHIFT);
    assign rem_full = mag_reg - ((quot << 3) + (quot << 1));
    assign digit    = rem_full[DW-1:0];
    assign cnt_inc  = cnt_reg + 1'b1;
    assign cnt_dec  = cnt_reg - 1'b1;

    assign out_load = !m_tvalid_reg || m_tready;
    assign q_rd     = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        emit_char  = sitda_pkg::ASCII_MINUS;
        emit_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_CONV;
                    cnt_next   = '0;
                end
            end
            ST_CONV: begin
                cnt_next = cnt_inc;
                if (quot == '0 || cnt_inc == CW'(MAX_DIGITS)) begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_load) begin
                    emit       = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                emit_char = sitda_pkg::ASCII_ZERO | {{(sitda_pkg::CHAR_W-DW){1'b0}},
                                                     store_reg[cnt_dec[IW-1:0]]};
                emit_last = (cnt_dec == '0);
                if (out_load) begin
                    emit     = 1'b1;
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_rd) begin
            neg_reg <= q_rdata.neg;
            mag_reg <= q_rdata.mag;
        end else if (state_reg == ST_CONV) begin
            mag_reg <= quot;
        end
        if (state_reg == ST_CONV) begin
            store_reg[cnt_reg[IW-1:0]] <= digit;
        end
        if (emit) begin
            m_tdata_reg <= emit_char;
            m_tlast_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                m_tvalid_reg <= emit;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

// File: design/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Each transfer on s_ carries one two's complement integer; the block answers with its
// decimal text on m_, one character per transfer, most significant first, with '-' ahead
// of negative values, a single '0' for zero and tlast on the final character. The input
// side stores jobs in a two-entry queue, so it keeps taking numbers while the converter
// works. The converter fetches a job, forms its digits through a reciprocal-multiply
// divide-by-ten unit into the digit store, then sends the characters through the output
// register, waiting while the receiver holds off, and fetches the next job only after
// the last character. With MAX_DIGITS below the number's digit count only the MAX_DIGITS
// least significant digits are sent.
`default_nettype none
module signed_int_to_decimal_ascii_core #(
    parameter int MAX_DIGITS = sitda_pkg::MAX_DIGITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] ascii_char
    output logic             m_tlast    // last_char
);

    logic            q_wr;
    logic            q_full;
    logic            q_valid;
    logic            q_rd;
    sitda_pkg::job_t q_wdata;
    sitda_pkg::job_t q_rdata;

    sitda_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata),
        .q_full   (q_full)
    );

    sitda_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (q_wr),
        .wdata    (q_wdata),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd       (q_rd),
        .rdata    (q_rdata)
    );

    sitda_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rd     (q_rd),
        .q_rdata  (q_rdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// File: design/sitda_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none
module sitda_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == sitda_pkg::ASCII_MINUS ||
                      (m_tdata >= 8'h30 && m_tdata <= 8'h39)))
        else $error("character outside sign and digits");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == sitda_pkg::ASCII_MINUS |-> !m_tlast)
        else $error("sign character flagged last");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// File: bench/sitda_text_checker.sv
// Checker for the integer to decimal text converter: predicts each character run and compares.
module sitda_text_checker #(
    parameter int MAX_DIGITS = sitda_pkg::MAX_DIGITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // [7:0] ascii_char
    input  wire logic        m_tlast,   // last_char
    output int               fail_count,
    output int               chars_pending
);

    localparam int CW = sitda_pkg::CHAR_W;
    localparam int DW = sitda_pkg::DIGIT_W;
    localparam int VW = sitda_pkg::VALUE_W;

    typedef struct packed {
        logic [CW-1:0] ch;
        logic          last;
    } text_char_t;

    text_char_t expected_text[$];
    int         errs = 0;
    int         pend = 0;

    assign fail_count    = errs;
    assign chars_pending = pend;

    task automatic report_mismatch(input string msg);
        // keep the log short on a badly broken build, but count everything
        if (errs < 50) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        errs++;
    endtask

    // Expected characters for one number, most significant first.
    function automatic void queue_text(input logic [VW-1:0] raw);
        logic [DW-1:0] digits [MAX_DIGITS];
        logic [VW-1:0] mag;
        int            n;
        mag = raw[VW-1] ? (~raw + 1'b1) : raw;
        if (mag == '0) begin
            expected_text.push_back('{ch: sitda_pkg::ASCII_ZERO, last: 1'b1});
            return;
        end
        if (raw[VW-1]) begin
            expected_text.push_back('{ch: sitda_pkg::ASCII_MINUS, last: 1'b0});
        end
        n = 0;
        // a short digit store keeps only the low-order digits
        while (mag != '0 && n < MAX_DIGITS) begin
            digits[n] = DW'(mag % 10);
            mag       = mag / 10;
            n++;
        end
        for (int i = n - 1; i >= 0; i--) begin
            expected_text.push_back('{ch: sitda_pkg::ASCII_ZERO + CW'(digits[i]),
                                      last: (i == 0)});
        end
    endfunction

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h last %0b with nothing expected",
                                              m_tdata, m_tlast));
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch) begin
                        report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                                  m_tdata, want.ch));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("tlast %0b on char 0x%02h, expected %0b",
                                                  m_tlast, want.ch, want.last));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                queue_text(s_tdata);
            end
        end
        pend = expected_text.size();
    end

endmodule

// File: bench/signed_int_to_decimal_ascii_core_tb.sv
// Testbench top for the integer to decimal text converter: clock, reset, stimulus and verdict.
module signed_int_to_decimal_ascii_core_tb;

    localparam int RAND_PER_PHASE = 110;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 300000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] ascii_char
    logic        m_tlast;         // last_char

    int fail_count;
    int chars_pending;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit long_hold_req  = 1'b0;
    int cycle_count    = 0;

    signed_int_to_decimal_ascii_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sitda_text_checker text_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0]     v;
        longint unsigned lo;
        longint unsigned hi;
        int              d;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = $urandom_range(999);
            2: begin
                // pick a digit count, then a magnitude with exactly that many digits
                d  = $urandom_range(10, 1);
                lo = 1;
                for (int i = 1; i < d; i++) lo = lo * 10;
                hi = lo * 10 - 1;
                if (d == 1) lo = 0;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                v = $urandom_range(32'(hi), 32'(lo));
            end
            3: begin
                // just around a power of ten
                lo = 1;
                for (int i = $urandom_range(9); i > 0; i--) lo = lo * 10;
                v = 32'(lo) + $urandom_range(2) - 1;
            end
            default: begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
            end
        endcase
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    initial begin
        logic [31:0] directed [$];
        directed = {32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                    32'd999999999, -32'd999999999, -32'd1000000000, 32'h7FFF_FFFE,
                    32'd123456789, -32'd5, 32'hAAAA_AAAA, 32'h5555_5555};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_value(directed[i]);

        // no idling; the receiver holds off long so the input side fills and stalls
        long_hold_req = 1'b1;
        for (int i = 0; i < RAND_PER_PHASE; i++) send_value(rand_value());

        src_idle_pct   = 50;
        sink_stall_pct = 0;
        for (int i = 0; i < RAND_PER_PHASE; i++) send_value(rand_value());

        src_idle_pct   = 0;
        sink_stall_pct = 50;
        for (int i = 0; i < RAND_PER_PHASE; i++) send_value(rand_value());

        src_idle_pct   = 27;
        sink_stall_pct = 27;
        for (int i = 0; i < RAND_PER_PHASE; i++) send_value(rand_value());

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && chars_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
design/sitda_pkg.sv
design/sitda_front.sv
design/sitda_queue.sv
design/sitda_back.sv
design/signed_int_to_decimal_ascii_core.sv
design/sitda_checker.sv
bench/sitda_text_checker.sv
bench/signed_int_to_decimal_ascii_core_tb.sv
